// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SID_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SID_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SID_ASSERT(lbl, clk, rst_n, prop, msg)
`define SID_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== sv/sid_pkg.sv =====
// ---------------------------------------------------------------------------
// Segment ID allocator package
// Field widths, command and status codes, table word layout.
// ---------------------------------------------------------------------------
package sid_pkg;

    localparam int ID_W     = 10;
    localparam int LEN_W    = 32;
    // wide enough to hold any ID count up to 65536
    localparam int ID_EXT_W = 17;

    typedef enum logic [1:0] {
        CMD_MAP      = 2'd0,
        CMD_UNMAP    = 2'd1,
        CMD_MAP_ZERO = 2'd2,
        CMD_QUERY    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ID      = 2'd1,
        ST_NOT_MAPPED = 2'd2
    } t_status;

    typedef struct packed {
        logic             mapped;
        logic [LEN_W-1:0] length;
    } t_tbl_word;

endpackage

// ===== sv/segment_id_allocator.sv =====
// ---------------------------------------------------------------------------
// Segment ID allocator
// Hands out segment IDs from a LIFO free stack or a fresh counter, frees them and reports their lengths.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_command, i_segment_id, i_segment_size and raise
//   start; the item is taken on a clock edge where start is high and busy low.
//   Result channel: o_valid is high for exactly one cycle with o_result_id,
//   o_result_length and o_status. The receiver cannot stall, so the result
//   must be captured in that cycle.
//   Sequence: the accepting edge registers the item and enters S_EXEC; the
//   result registers, o_valid among them, load as S_EXEC is left.
//   A new item is not taken until the previous one has written back. The item
//   reads the free stack and the segment table (synchronous reads) when it is
//   accepted and writes back in S_EXEC; busy holds off the next item
//   meanwhile, so accesses to the same entry never overlap.
//   A new item may be taken in the cycle in which the previous result is shown.
//   Reset: synchronous, active low. Mapped flags and lengths are cleared by a
//   sweep over all NUM_IDS entries after reset, during which busy stays high.
//   Free count and fresh ID counter start at zero; the stack is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_id_allocator #(
    parameter int NUM_IDS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [sid_pkg::ID_W-1:0]    i_segment_id,
    input  logic [sid_pkg::LEN_W-1:0]   i_segment_size,
    output logic                        o_valid,
    output logic [sid_pkg::ID_W-1:0]    o_result_id,
    output logic [sid_pkg::LEN_W-1:0]   o_result_length,
    output logic [1:0]                  o_status
);

    localparam int IW = $clog2(NUM_IDS);
    localparam int CW = $clog2(NUM_IDS + 1);
    localparam logic [CW-1:0] NUM_IDS_CW = CW'(NUM_IDS);
    localparam logic [sid_pkg::ID_EXT_W-1:0] NUM_IDS_EXT = sid_pkg::ID_EXT_W'(NUM_IDS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // free stack memory
    logic [IW-1:0] r_stack [NUM_IDS];
    logic [IW-1:0] r_stk_rd;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_free_count, n_free_count;
    logic [IW-1:0]             r_highest, n_highest;
    logic                      r_valid, n_valid;
    logic [sid_pkg::ID_W-1:0]  r_res_id, n_res_id;
    logic [sid_pkg::LEN_W-1:0] r_res_len, n_res_len;
    sid_pkg::t_status          r_status, n_status;

    sid_pkg::t_cmd             r_cmd;
    logic [sid_pkg::ID_W-1:0]  r_id;
    logic [sid_pkg::LEN_W-1:0] r_size;

    logic                      tbl_ready;
    logic                      accept;
    logic [IW-1:0]             in_addr;
    logic [IW-1:0]             id_addr;
    logic                      id_in_range;
    logic [sid_pkg::ID_EXT_W-1:0] fresh_ext;
    logic [IW-1:0]             next_id;
    sid_pkg::t_tbl_word        tbl_rd;
    logic                      tbl_wr_en;
    logic [IW-1:0]             tbl_wr_addr;
    sid_pkg::t_tbl_word        tbl_wr_data;
    logic                      stk_wr_en;

    assign busy    = (r_state != S_IDLE) || !tbl_ready;
    assign accept  = start && !busy;
    assign in_addr = IW'(sid_pkg::ID_EXT_W'(i_segment_id));
    assign id_addr = IW'(sid_pkg::ID_EXT_W'(r_id));
    assign id_in_range = sid_pkg::ID_EXT_W'(r_id) < NUM_IDS_EXT;
    assign fresh_ext   = sid_pkg::ID_EXT_W'(r_highest) + sid_pkg::ID_EXT_W'(1);

    sid_table #(
        .NUM_IDS (NUM_IDS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_addr),
        .o_rd_data (tbl_rd),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .o_ready   (tbl_ready)
    );

    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            r_stack[r_free_count[IW-1:0]] <= id_addr;
        end
        if (accept) begin
            // top of stack; garbage when empty, unused then
            r_stk_rd <= r_stack[IW'(r_free_count - 1'b1)];
            r_cmd    <= sid_pkg::t_cmd'(i_command);
            r_id     <= i_segment_id;
            r_size   <= i_segment_size;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free_count = r_free_count;
        n_highest    = r_highest;
        n_valid      = 1'b0;
        n_res_id     = r_res_id;
        n_res_len    = r_res_len;
        n_status     = r_status;
        next_id      = '0;
        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = id_addr;
        tbl_wr_data  = '0;
        stk_wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state   = S_IDLE;
                n_valid   = 1'b1;
                n_res_id  = r_id;
                n_res_len = '0;
                n_status  = sid_pkg::ST_OK;
                unique case (r_cmd)
                    sid_pkg::CMD_MAP: begin
                        if (r_free_count != '0) begin
                            next_id      = r_stk_rd;
                            n_free_count = r_free_count - 1'b1;
                        end else if (fresh_ext < NUM_IDS_EXT) begin
                            next_id   = r_highest + 1'b1;
                            n_highest = r_highest + 1'b1;
                        end else begin
                            n_status = sid_pkg::ST_NO_ID;
                        end
                        if (n_status == sid_pkg::ST_OK) begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_addr = next_id;
                            tbl_wr_data = '{mapped: 1'b1, length: r_size};
                            n_res_id    = sid_pkg::ID_W'(sid_pkg::ID_EXT_W'(next_id));
                        end else begin
                            n_res_id = '0;
                        end
                    end
                    sid_pkg::CMD_UNMAP: begin
                        if (!id_in_range || !tbl_rd.mapped) begin
                            n_status = sid_pkg::ST_NOT_MAPPED;
                        end else begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_data = '{mapped: 1'b0, length: tbl_rd.length};
                            // a full stack drops the push
                            if (r_free_count < NUM_IDS_CW) begin
                                stk_wr_en    = 1'b1;
                                n_free_count = r_free_count + 1'b1;
                            end
                        end
                    end
                    sid_pkg::CMD_MAP_ZERO: begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_addr = '0;
                        tbl_wr_data = '{mapped: 1'b1, length: r_size};
                        n_res_id    = '0;
                    end
                    sid_pkg::CMD_QUERY: begin
                        if (id_in_range && tbl_rd.mapped) begin
                            n_res_len = tbl_rd.length;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_highest    <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_highest    <= n_highest;
            r_valid      <= n_valid;
            r_res_id     <= n_res_id;
            r_res_len    <= n_res_len;
            r_status     <= n_status;
        end
    end

    assign o_valid         = r_valid;
    assign o_result_id     = r_res_id;
    assign o_result_length = r_res_len;
    assign o_status        = r_status;

    `SID_ASSERT(a_busy_after_accept, i_clk, i_rst_n, start && !busy |=> busy, "accepted item did not raise busy")
    `SID_ASSERT(a_valid_from_exec, i_clk, i_rst_n, o_valid |-> $past(r_state == S_EXEC), "result strobe without an executed item")
    `SID_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_free_count > NUM_IDS_CW, "free count above ID count")
    `SID_ASSERT(a_no_id_empty, i_clk, i_rst_n, o_valid && o_status == sid_pkg::ST_NO_ID |-> r_free_count == '0 && o_result_id == '0, "out of IDs with stack not empty")
    `SID_ASSERT_NEVER(a_status_code, i_clk, i_rst_n, o_valid && o_status != sid_pkg::ST_OK && o_status != sid_pkg::ST_NO_ID && o_status != sid_pkg::ST_NOT_MAPPED, "undefined status code")

endmodule

// ===== sv/sid_table.sv =====
// ---------------------------------------------------------------------------
// Segment table
// One-port-read, one-port-write memory of mapped flag and length per ID,
// swept to all zero after reset.
// ---------------------------------------------------------------------------
module sid_table #(
    parameter int NUM_IDS = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_rd_en,
    input  logic [$clog2(NUM_IDS)-1:0]              i_rd_addr,
    output sid_pkg::t_tbl_word                      o_rd_data,
    input  logic                                    i_wr_en,
    input  logic [$clog2(NUM_IDS)-1:0]              i_wr_addr,
    input  sid_pkg::t_tbl_word                      i_wr_data,
    output logic                                    o_ready
);

    localparam int IW = $clog2(NUM_IDS);
    localparam logic [IW-1:0] LAST_ADDR = IW'(NUM_IDS - 1);

    sid_pkg::t_tbl_word r_mem [NUM_IDS];
    sid_pkg::t_tbl_word r_rd_data;
    logic               r_clr_busy;
    logic [IW-1:0]      r_clr_addr;

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    sid_pkg::t_tbl_word wr_data;

    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_busy;

endmodule
